// ===== sv/fpba_pkg.sv =====
package fpba_pkg;

    // Fixed field widths of the command, result and configuration words
    localparam int INDEX_W    = 3;
    localparam int CAP_W      = 16;
    localparam int MODE_W     = 2;
    localparam int BLK_CNT_W  = 4;

    // Allocation policy codes
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam logic [MODE_W-1:0]    FIT_MODE_RESET      = MODE_FIRST;
    localparam logic [BLK_CNT_W-1:0] BLOCKS_IN_USE_RESET = 4'd8;

    // Command action codes
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_ALLOCATE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] block_index;
        logic [CAP_W-1:0]   block_capacity;
        logic [CAP_W-1:0]   request_size;
    } item_t;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] chosen_block;
        logic [CAP_W-1:0]   capacity_left;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0]    fit_mode;
        logic [BLK_CNT_W-1:0] blocks_in_use;
    } cfg_t;

endpackage

// ===== sv/fpba_regs.sv =====
module fpba_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fpba_pkg::cfg_t    cfg
);
    import fpba_pkg::*;

    logic [MODE_W-1:0]    fit_mode_reg;
    logic [BLK_CNT_W-1:0] blocks_reg;
    logic                 wr_en;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // Registers sit on word boundaries: bit 2 picks the register
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= FIT_MODE_RESET;
            blocks_reg   <= BLOCKS_IN_USE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_FIT_MODE:      fit_mode_reg <= pwdata[MODE_W-1:0];
                REG_BLOCKS_IN_USE: blocks_reg   <= pwdata[BLK_CNT_W-1:0];
                default:           fit_mode_reg <= fit_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_FIT_MODE:      prdata[MODE_W-1:0]    = fit_mode_reg;
            REG_BLOCKS_IN_USE: prdata[BLK_CNT_W-1:0] = blocks_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.fit_mode      = fit_mode_reg;
    assign cfg.blocks_in_use = blocks_reg;

endmodule

// ===== sv/fpba_cap_mem.sv =====
module fpba_cap_mem #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [SIZE_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr,
    output logic [SIZE_BITS-1:0] rdata
);

    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [SIZE_BITS-1:0]  rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Entry valid bits stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/fpba_ctrl.sv =====
module fpba_ctrl #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 3,
    parameter int CNT_W      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fpba_pkg::item_t      item,
    output logic                 busy,
    input  fpba_pkg::cfg_t       cfg,
    output logic                 done,
    output fpba_pkg::result_t    result,
    output logic                 mem_we,
    output logic [IDX_W-1:0]     mem_waddr,
    output logic [SIZE_BITS-1:0] mem_wdata,
    output logic                 mem_re,
    output logic [IDX_W-1:0]     mem_raddr,
    input  logic [SIZE_BITS-1:0] mem_rdata
);
    import fpba_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]           state_reg,     state_next;
    logic [IDX_W-1:0]     pos_reg,       pos_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]     eval_cnt_reg,  eval_cnt_next;
    logic                 rd_vld_reg,    rd_vld_next;
    logic [IDX_W-1:0]     rd_pos_reg,    rd_pos_next;
    logic                 found_reg,     found_next;
    logic [IDX_W-1:0]     best_pos_reg,  best_pos_next;
    logic [SIZE_BITS-1:0] best_cap_reg,  best_cap_next;
    logic [SIZE_BITS-1:0] req_reg,       req_next;
    logic [IDX_W-1:0]     ptr_reg,       ptr_next;
    logic                 done_reg,      done_next;
    result_t              result_reg,    result_next;

    logic                 accept;
    logic [CNT_W-1:0]     active_n;
    logic [IDX_W-1:0]     start_pos;
    logic [IDX_W-1:0]     pos_wrap;
    logic                 in_table;
    logic [SIZE_BITS-1:0] cap_in;
    logic [SIZE_BITS-1:0] cap_after;
    logic                 fits;
    logic                 take;
    logic                 stop_first;
    logic                 last_eval;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Saturate the active count to the table size
    assign active_n = (32'(cfg.blocks_in_use) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                            : CNT_W'(cfg.blocks_in_use);

    assign start_pos = ((cfg.fit_mode == MODE_NEXT) && (CNT_W'(ptr_reg) < active_n))
                       ? ptr_reg : '0;
    assign pos_wrap  = ((CNT_W'(pos_reg) + CNT_W'(1)) < active_n)
                       ? IDX_W'(pos_reg + IDX_W'(1)) : '0;

    assign in_table  = (32'(item.block_index) < NUM_BLOCKS);
    assign cap_in    = SIZE_BITS'(item.block_capacity);
    assign cap_after = best_cap_reg - req_reg;

    assign fits       = (mem_rdata >= req_reg);
    assign stop_first = fits && ((cfg.fit_mode == MODE_FIRST) || (cfg.fit_mode == MODE_NEXT));
    assign last_eval  = ((eval_cnt_reg + CNT_W'(1)) == active_n);

    always_comb
    begin
        unique case (cfg.fit_mode)
            MODE_FIRST, MODE_NEXT: take = fits;
            MODE_BEST:  take = fits && (!found_reg || (mem_rdata < best_cap_reg));
            MODE_WORST: take = fits && (!found_reg || (mem_rdata > best_cap_reg));
            default:    take = 1'b0;
        endcase
    end

    // Memory ports: reads walk the scan, writes come from loads or the grant
    assign mem_re    = (state_reg == ST_SCAN) && (issue_cnt_reg < active_n);
    assign mem_raddr = pos_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = best_pos_reg;
        mem_wdata = cap_after;
        if (state_reg == ST_WRITE)
        begin
            mem_we = 1'b1;
        end
        else if (accept && (item.action == ACT_LOAD) && in_table)
        begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(item.block_index);
            mem_wdata = cap_in;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        issue_cnt_next = issue_cnt_reg;
        eval_cnt_next  = eval_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_pos_next    = rd_pos_reg;
        found_next     = found_reg;
        best_pos_next  = best_pos_reg;
        best_cap_next  = best_cap_reg;
        req_next       = req_reg;
        ptr_next       = ptr_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.action == ACT_LOAD)
                    begin
                        done_next                 = 1'b1;
                        result_next.granted       = 1'b0;
                        result_next.chosen_block  = item.block_index;
                        result_next.capacity_left = in_table ? CAP_W'(cap_in) : '0;
                    end
                    else if (active_n == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        state_next     = ST_SCAN;
                        pos_next       = start_pos;
                        issue_cnt_next = '0;
                        eval_cnt_next  = '0;
                        found_next     = 1'b0;
                        req_next       = SIZE_BITS'(item.request_size);
                    end
                end
            end

            ST_SCAN:
            begin
                if (mem_re)
                begin
                    pos_next       = pos_wrap;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    rd_vld_next    = 1'b1;
                    rd_pos_next    = pos_reg;
                end
                if (rd_vld_reg)
                begin
                    eval_cnt_next = eval_cnt_reg + CNT_W'(1);
                    if (take)
                    begin
                        found_next    = 1'b1;
                        best_pos_next = rd_pos_reg;
                        best_cap_next = mem_rdata;
                    end
                    if (stop_first || last_eval)
                    begin
                        rd_vld_next = 1'b0;
                        if (found_reg || take)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            state_next  = ST_IDLE;
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    end
                end
            end

            ST_WRITE:
            begin
                state_next                = ST_IDLE;
                done_next                 = 1'b1;
                result_next.granted       = 1'b1;
                result_next.chosen_block  = INDEX_W'(best_pos_reg);
                result_next.capacity_left = CAP_W'(cap_after);
                if (cfg.fit_mode == MODE_NEXT)
                begin
                    ptr_next = best_pos_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            eval_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            ptr_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            eval_cnt_reg  <= eval_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            ptr_reg       <= ptr_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        rd_pos_reg   <= rd_pos_next;
        best_pos_reg <= best_pos_next;
        best_cap_reg <= best_cap_next;
        req_reg      <= req_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/fit_policy_block_allocator_top.sv =====
// Channel  | Handshake             | Payload       | Notes
// ---------+-----------------------+---------------+------------------------------
// command  | start / busy          | item          | word taken when start && !busy
// result   | done (one-cycle)      | result        | always taken, no back-pressure
// config   | psel/penable/pwrite   | paddr, pwdata | APB, pready tied high
//
// A load word needs no scan; its result strobes on the next cycle and
// busy stays low, so loads can stream one per cycle.
// An allocate word walks the active blocks through the single read port of the
// capacity memory, one compare per cycle behind its registered read port:
// busy holds through the scan and any write-back, and the result strobes
// as busy drops. First and next fit stop at the first fitting block.
// Reset restores policy and block count defaults, clears the next-fit pointer;
// per-entry valid bits make every capacity read as zero until loaded, so no clearing pass is needed.
// The result side never stalls: each result is shown for exactly one cycle.
module fit_policy_block_allocator_top #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fpba_pkg::item_t      item,
    output logic                 busy,
    output logic                 done,
    output fpba_pkg::result_t    result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import fpba_pkg::*;

    // Index and count widths follow the table size
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1) > BLK_CNT_W ? $clog2(NUM_BLOCKS + 1)
                                                              : BLK_CNT_W;

    cfg_t                 cfg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic [SIZE_BITS-1:0] mem_rdata;

    // Policy and block count registers
    fpba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Remaining capacity table: one write port, one registered read port
    fpba_cap_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_cap_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Scan sequencer: read, compare, then write back the shrunk capacity
    fpba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .cfg       (cfg),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // A taken load word answers on the very next cycle
    a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action == ACT_LOAD)) |=> done)
        else $error("load word without result");

    // The scan only starts from a taken command word
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // Every finished scan delivers its result as busy drops
    a_scan_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without result");

    // Memory is never written while a scan read is in flight
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> !mem_we)
        else $error("capacity write during scan");

endmodule
